>>> rtl/cell_list_neighbor_search_assert.svh
// Assertion macros used by cell_list_neighbor_search.sv.
`ifndef CELL_LIST_NEIGHBOR_SEARCH_ASSERT_SVH
`define CELL_LIST_NEIGHBOR_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define CLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/cls_pkg.sv
package cls_pkg;

   localparam int GRID_DIM_MAX_DEF = 16;
   localparam int INDEX_BITS_DEF   = 16;
   localparam int MAX_HALF_DEF     = 1;

   localparam int REQ_W   = 2;
   localparam int IDX_W   = 16;
   localparam int FRAC_W  = 16;
   localparam int CUT_W   = 32;
   localparam int GRID_W  = 5;
   localparam int LEN_W   = 16;
   localparam int PROD_W  = 32;
   localparam int SQ_W    = 64;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z  = 3'd6;

   localparam logic [GRID_W-1:0] GRID_RESET = 5'd4;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 16'd256;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_BIN,
      ST_ADDR1,
      ST_ADDR2,
      ST_RDWAIT,
      ST_SQ,
      ST_SUM,
      ST_CMP,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] neighbor_index;
      logic [CUT_W-1:0] dist_sq;
      logic             found;
      logic             collision;
      logic             last;
   } rsp_data_type;

endpackage

>>> rtl/cls_req_if.sv
interface cls_req_if;
   import cls_pkg::*;

   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [IDX_W-1:0]  atom_index;
   logic [FRAC_W-1:0] frac_x;
   logic [FRAC_W-1:0] frac_y;
   logic [FRAC_W-1:0] frac_z;
   logic              full_list;
   logic [CUT_W-1:0]  cutoff_sq;

   modport source (output valid, req_type, atom_index, frac_x, frac_y, frac_z,
                   full_list, cutoff_sq, input ready);
   modport sink (input valid, req_type, atom_index, frac_x, frac_y, frac_z,
                 full_list, cutoff_sq, output ready);
endinterface

>>> rtl/cls_rsp_if.sv
interface cls_rsp_if;
   import cls_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] neighbor_index;
   logic [CUT_W-1:0] dist_sq;
   logic             found;
   logic             collision;
   logic             last;

   modport source (output valid, neighbor_index, dist_sq, found, collision, last,
                   input ready);
   modport sink (input valid, neighbor_index, dist_sq, found, collision, last,
                 output ready);
endinterface

>>> rtl/cell_list_neighbor_search.sv
// A query visits up to 27 subcells in turn: each is read from the single-port cell
// memory and, unless empty or skipped, goes through the two-stage multiply. An
// insert reads its cell, then writes it. Clear writes one memory row per cycle.
// One request at a time. Reset is synchronous, active high; after reset the cell
// memory is swept empty before a request is taken. CSR writes are always taken.
`include "cell_list_neighbor_search_assert.svh"

module cell_list_neighbor_search #(
   parameter int GRID_DIM_MAX = cls_pkg::GRID_DIM_MAX_DEF,
   parameter int INDEX_BITS   = cls_pkg::INDEX_BITS_DEF,
   parameter int MAX_HALF     = cls_pkg::MAX_HALF_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   cls_req_if.sink                       req_bus,
   cls_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [cls_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cls_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cls_pkg::*;

   localparam int CW    = (GRID_DIM_MAX > 1) ? $clog2(GRID_DIM_MAX) : 1;
   localparam int DW    = $clog2(GRID_DIM_MAX + 1);
   localparam int CELLS = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW    = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
   localparam int RW    = 1 + SW + 3 * FRAC_W;

   function automatic logic [DW-1:0] dim_eff(input logic [GRID_W-1:0] g);
      logic [DW-1:0] r;
      if (g == '0) begin
         r = DW'(1);
      end else if (int'(g) > GRID_DIM_MAX) begin
         r = DW'(GRID_DIM_MAX);
      end else begin
         r = DW'(g);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] wrap_axis(input logic [CW-1:0] c,
                                               input logic signed [1:0] d,
                                               input logic [DW-1:0] n);
      logic signed [CW+1:0] v;
      logic signed [CW+1:0] ns;
      v  = $signed({2'b00, c}) + d;
      ns = $signed((CW+2)'(n));
      if (v < 0) begin
         v = v + ns;
      end else if (v > ns - 1) begin
         v = v - ns;
      end
      return v[CW-1:0];
   endfunction

   function automatic logic [FRAC_W-1:0] abs_diff(input logic [FRAC_W-1:0] a,
                                                  input logic [FRAC_W-1:0] b);
      logic [FRAC_W-1:0] d;
      d = b - a;
      return d[FRAC_W-1] ? (~d + 1'b1) : d;
   endfunction

   // Configuration registers
   logic [GRID_W-1:0] gx_ff, gy_ff, gz_ff;
   logic              half_ff;
   logic [LEN_W-1:0]  lx_ff, ly_ff, lz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff   <= GRID_RESET;
         gy_ff   <= GRID_RESET;
         gz_ff   <= GRID_RESET;
         half_ff <= 1'b1;
         lx_ff   <= LEN_RESET;
         ly_ff   <= LEN_RESET;
         lz_ff   <= LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_X: gx_ff   <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Y: gy_ff   <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Z: gz_ff   <= csr_wdata[GRID_W-1:0];
            CSR_HALF:   half_ff <= csr_wdata[0];
            CSR_BOX_X:  lx_ff   <= csr_wdata[LEN_W-1:0];
            CSR_BOX_Y:  ly_ff   <= csr_wdata[LEN_W-1:0];
            CSR_BOX_Z:  lz_ff   <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] nx, ny, nz;
   assign nx = dim_eff(gx_ff);
   assign ny = dim_eff(gy_ff);
   assign nz = dim_eff(gz_ff);

   // Control state
   state_type        state_ff, state_in;
   logic [AW:0]      sweep_ff, sweep_in;
   logic             sweep_req_ff, sweep_req_in;
   logic             pend_v_ff, pend_v_in;
   logic             rsp_v_ff, rsp_v_in;

   // Payload
   logic [REQ_W-1:0]  op_ff, op_in;
   logic [SW-1:0]     me_ff, me_in;
   logic [FRAC_W-1:0] fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic              full_ff, full_in;
   logic [CUT_W-1:0]  cut_ff, cut_in;
   logic [CW-1:0]     ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic              h_ff, h_in;
   logic signed [1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [CW-1:0]     wi_ff, wi_in;
   logic [AW-1:0]     row_ff, row_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              col_ff, col_in;
   logic [SW-1:0]     other_ff, other_in;
   logic [PROD_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [SQ_W-1:0]   sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [CUT_W-1:0]  d_ff, d_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [CUT_W-1:0]  pend_d_ff, pend_d_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   // Memory port
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [RW-1:0] ram_wdata;
   logic [RW-1:0] ram_rdata;

   cls_ram #(.WIDTH(RW), .DEPTH(CELLS), .AW(AW)) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   logic              rd_valid;
   logic [SW-1:0]     rd_atom;
   logic [FRAC_W-1:0] rd_px, rd_py, rd_pz;
   assign rd_valid = ram_rdata[RW-1];
   assign rd_atom  = ram_rdata[3*FRAC_W +: SW];
   assign rd_px    = ram_rdata[2*FRAC_W +: FRAC_W];
   assign rd_py    = ram_rdata[FRAC_W +: FRAC_W];
   assign rd_pz    = ram_rdata[0 +: FRAC_W];

   logic out_free;
   logic out_load;
   assign out_free = !rsp_v_ff || rsp_bus.ready;

   // Stencil walk: dx fastest, then dy, then dz.
   logic signed [1:0] neg_h, pos_h;
   logic              last_x, last_y, last_z, walk_done;
   logic signed [1:0] ndx, ndy, ndz;
   assign pos_h  = $signed({1'b0, h_ff});
   assign neg_h  = -pos_h;
   assign last_x = (dx_ff == pos_h);
   assign last_y = (dy_ff == pos_h);
   assign last_z = (dz_ff == pos_h);
   assign walk_done = last_x && last_y && last_z;

   always_comb begin
      ndx = last_x ? neg_h : dx_ff + 2'sd1;
      ndy = dy_ff;
      ndz = dz_ff;
      if (last_x) begin
         ndy = last_y ? neg_h : dy_ff + 2'sd1;
         if (last_y) begin
            ndz = dz_ff + 2'sd1;
         end
      end
   end

   logic [CW-1:0] wk, wj;
   logic [AW-1:0] q_addr;
   logic          skip;
   logic          hit;
   logic [CW-1:0] bin_x, bin_y, bin_z;
   logic [FRAC_W+DW-1:0] bprod_x, bprod_y, bprod_z;

   assign wk = wrap_axis(ck_ff, dz_ff, nz);
   assign wj = wrap_axis(cj_ff, dy_ff, ny);
   assign q_addr = row_ff * AW'(nx) + AW'(wi_ff);
   assign skip = !rd_valid || (rd_atom == me_ff) || ((rd_atom > me_ff) && !full_ff);
   assign hit  = d_ff < cut_ff;

   assign bprod_x = fx_ff * nx;
   assign bprod_y = fy_ff * ny;
   assign bprod_z = fz_ff * nz;
   assign bin_x = bprod_x[FRAC_W +: CW];
   assign bin_y = bprod_y[FRAC_W +: CW];
   assign bin_z = bprod_z[FRAC_W +: CW];

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_req_in = sweep_req_ff;
      pend_v_in    = pend_v_ff;
      op_in        = op_ff;
      me_in        = me_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      fz_in        = fz_ff;
      full_in      = full_ff;
      cut_in       = cut_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      ck_in        = ck_ff;
      h_in         = h_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      wi_in        = wi_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      col_in       = col_ff;
      other_in     = other_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      d_in         = d_ff;
      pend_idx_in  = pend_idx_ff;
      pend_d_in    = pend_d_ff;
      rsp_data_in  = rsp_data_ff;
      out_load     = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = addr_ff;
      ram_wdata    = '0;
      req_bus.ready = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            ram_we   = 1'b1;
            ram_addr = sweep_ff[AW-1:0];
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (AW+1)'(CELLS - 1)) begin
               state_in     = sweep_req_ff ? ST_FINISH : ST_IDLE;
               sweep_req_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in     = req_bus.req_type;
               me_in     = req_bus.atom_index[SW-1:0];
               fx_in     = req_bus.frac_x;
               fy_in     = req_bus.frac_y;
               fz_in     = req_bus.frac_z;
               full_in   = req_bus.full_list;
               cut_in    = req_bus.cutoff_sq;
               col_in    = 1'b0;
               pend_v_in = 1'b0;
               case (req_bus.req_type)
                  REQ_CLEAR: begin
                     sweep_in     = '0;
                     sweep_req_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  REQ_INSERT, REQ_QUERY: state_in = ST_BIN;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_BIN: begin
            ci_in = bin_x;
            cj_in = bin_y;
            ck_in = bin_z;
            h_in  = (op_ff == REQ_QUERY) && (MAX_HALF > 0) && half_ff;
            dx_in = (op_ff == REQ_QUERY && MAX_HALF > 0 && half_ff) ? -2'sd1 : 2'sd0;
            dy_in = dx_in;
            dz_in = dx_in;
            state_in = ST_ADDR1;
         end
         ST_ADDR1: begin
            row_in   = AW'(wk) * AW'(ny) + AW'(wj);
            wi_in    = wrap_axis(ci_ff, dx_ff, nx);
            state_in = ST_ADDR2;
         end
         ST_ADDR2: begin
            ram_addr = q_addr;
            addr_in  = q_addr;
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            if (op_ff == REQ_INSERT) begin
               col_in   = rd_valid;
               state_in = ST_WRITE;
            end else if (skip) begin
               if (walk_done) begin
                  state_in = ST_FINISH;
               end else begin
                  dx_in    = ndx;
                  dy_in    = ndy;
                  dz_in    = ndz;
                  state_in = ST_ADDR1;
               end
            end else begin
               other_in = rd_atom;
               px_in    = abs_diff(fx_ff, rd_px) * lx_ff;
               py_in    = abs_diff(fy_ff, rd_py) * ly_ff;
               pz_in    = abs_diff(fz_ff, rd_pz) * lz_ff;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sx_in    = px_ff * px_ff;
            sy_in    = py_ff * py_ff;
            sz_in    = pz_ff * pz_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            d_in     = CUT_W'((sx_ff + sy_ff + sz_ff) >> 32);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // A hit is parked until the next one shows that it is not the last beat.
            if (!hit || !pend_v_ff || out_free) begin
               if (hit) begin
                  if (pend_v_ff) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{neighbor_index: pend_idx_ff, dist_sq: pend_d_ff,
                                     found: 1'b1, collision: 1'b0, last: 1'b0};
                  end
                  pend_v_in   = 1'b1;
                  pend_idx_in = IDX_W'(other_ff);
                  pend_d_in   = d_ff;
               end
               if (walk_done) begin
                  state_in = ST_FINISH;
               end else begin
                  dx_in    = ndx;
                  dy_in    = ndy;
                  dz_in    = ndz;
                  state_in = ST_ADDR1;
               end
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, me_ff, fx_ff, fy_ff, fz_ff};
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pend_v_ff) begin
                  rsp_data_in = '{neighbor_index: pend_idx_ff, dist_sq: pend_d_ff,
                                  found: 1'b1, collision: 1'b0, last: 1'b1};
               end else begin
                  rsp_data_in = '{neighbor_index: '0, dist_sq: '0, found: 1'b0,
                                  collision: col_ff, last: 1'b1};
               end
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_v_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_req_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_req_ff <= sweep_req_in;
         pend_v_ff    <= pend_v_in;
         rsp_v_ff     <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      me_ff       <= me_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      fz_ff       <= fz_in;
      full_ff     <= full_in;
      cut_ff      <= cut_in;
      ci_ff       <= ci_in;
      cj_ff       <= cj_in;
      ck_ff       <= ck_in;
      h_ff        <= h_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      wi_ff       <= wi_in;
      row_ff      <= row_in;
      addr_ff     <= addr_in;
      col_ff      <= col_in;
      other_ff    <= other_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      d_ff        <= d_in;
      pend_idx_ff <= pend_idx_in;
      pend_d_ff   <= pend_d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid          = rsp_v_ff;
   assign rsp_bus.neighbor_index = rsp_data_ff.neighbor_index;
   assign rsp_bus.dist_sq        = rsp_data_ff.dist_sq;
   assign rsp_bus.found          = rsp_data_ff.found;
   assign rsp_bus.collision      = rsp_data_ff.collision;
   assign rsp_bus.last           = rsp_data_ff.last;

   `CLS_ASSERT_IMP(a_sweep_blocks_req, clock, reset, state_ff == ST_SWEEP, !req_bus.ready, "request taken during memory sweep")
   `CLS_ASSERT_IMP(a_out_load_free, clock, reset, out_load, out_free, "result register overwritten while a beat waits")
   `CLS_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_v_ff && !rsp_data_ff.found, rsp_data_ff.last, "result without a neighbor is not marked last")
   `CLS_ASSERT_NXT(a_finish_drains, clock, reset, state_ff == ST_FINISH && out_free, state_ff == ST_IDLE && !pend_v_ff, "finish did not release the pending neighbor")

endmodule

>>> rtl/cls_ram.sv
module cls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule
